[rtl/core/afb_pkg.sv]
`default_nettype none
package afb_pkg;

   localparam int unsigned CALL_W  = 48;
   localparam int unsigned CHARS   = 6;
   localparam int unsigned PHASE_W = 5;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam logic [7:0]  SSID_BASE  = 8'h60;
   localparam logic [7:0]  SSID_LAST  = 8'h01;
   localparam logic [7:0]  CTRL_UI    = 8'h03;
   localparam logic [7:0]  PID_NONE   = 8'hF0;
   localparam logic [7:0]  SHIFT_MASK = 8'hFE;
   localparam logic [7:0]  PAD_CHAR   = 8'h20;

   // Sequencer phases: 0..15 header bytes, then info and the two FCS bytes
   localparam logic [PHASE_W-1:0] PH_HDR_FIRST = 5'd0;
   localparam logic [PHASE_W-1:0] PH_HDR_LAST  = 5'd15;
   localparam logic [PHASE_W-1:0] PH_INFO      = 5'd16;
   localparam logic [PHASE_W-1:0] PH_FCS_LO    = 5'd17;
   localparam logic [PHASE_W-1:0] PH_FCS_HI    = 5'd18;

   typedef enum logic {
      CSR_DEST_CALL   = 1'b0,
      CSR_SOURCE_CALL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] info_byte;
      logic       has_byte;
      logic       end_of_info;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/core/afb_crc.sv]
`default_nettype none
module afb_crc
   import afb_pkg::*;
(
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data,
   output logic      [15:0] crc_next
);

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {8'h00, data};
      for (int j = 0; j < 8; j++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule
`default_nettype wire

[rtl/core/afb_hdr.sv]
`default_nettype none
module afb_hdr
   import afb_pkg::*;
(
   input  wire logic [CALL_W-1:0] dest_call,
   input  wire logic [CALL_W-1:0] src_call,
   input  wire logic [3:0]        idx,
   output logic      [7:0]        hdr_byte
);

   logic [7:0] dest_chr [CHARS];
   logic [7:0] src_chr  [CHARS];

   // Pad from the first zero character onwards, then shift into address form
   always_comb begin
      logic dest_end;
      logic src_end;
      logic [7:0] c;
      dest_end = 1'b0;
      src_end  = 1'b0;
      for (int k = 0; k < CHARS; k++) begin
         c = dest_call[CALL_W-1-8*k -: 8];
         if (c == 8'h00) dest_end = 1'b1;
         if (dest_end) c = PAD_CHAR;
         dest_chr[k] = {c[6:0], 1'b0} & SHIFT_MASK;
         c = src_call[CALL_W-1-8*k -: 8];
         if (c == 8'h00) src_end = 1'b1;
         if (src_end) c = PAD_CHAR;
         src_chr[k] = {c[6:0], 1'b0} & SHIFT_MASK;
      end
   end

   always_comb begin
      unique case (idx)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5:
            hdr_byte = dest_chr[3'(idx)];
         4'd6:
            hdr_byte = SSID_BASE;
         4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12:
            hdr_byte = src_chr[3'(idx - 4'd7)];
         4'd13:
            hdr_byte = SSID_BASE | SSID_LAST;
         4'd14:
            hdr_byte = CTRL_UI;
         default:
            hdr_byte = PID_NONE;
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/ax25_ui_frame_builder_fcs.sv]
`default_nettype none
// An accepted item is held in the item register; its first byte enters the result register
// when the output is not stalled. The byte sequencer yields one frame byte per cycle while
// the output is not stalled; an item yields 1 to 19 bytes, an empty mid-frame item none.
// The next item is taken in the cycle the current item's last byte is issued.
// Reset (synchronous, active high) clears callsigns, CRC to 0xFFFF, no frame open.
module ax25_ui_frame_builder_fcs
   import afb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data,
   input  wire logic          csr_wen,
   input  wire csr_index_type csr_index,
   input  wire logic [CALL_W-1:0] csr_wdata
);

   logic [CALL_W-1:0]  dest_ff, dest_in;
   logic [CALL_W-1:0]  src_ff, src_in;
   req_type            item_ff, item_in;
   logic               item_vld_ff, item_vld_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [15:0]        crc_ff, crc_in;
   logic               hdr_sent_ff, hdr_sent_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               step;
   logic               item_done;
   logic [PHASE_W-1:0] phase_nxt;
   logic [7:0]         hdr_byte;
   logic [7:0]         out_byte;
   logic [15:0]        crc_upd;
   logic               accept;
   logic               start_ok;
   logic [PHASE_W-1:0] start_phase;

   afb_hdr u_hdr (
      .dest_call (dest_ff),
      .src_call  (src_ff),
      .idx       (phase_ff[3:0]),
      .hdr_byte  (hdr_byte)
   );

   afb_crc u_crc (
      .crc_cur  (crc_ff),
      .data     (out_byte),
      .crc_next (crc_upd)
   );

   always_comb begin
      priority if (phase_ff <= PH_HDR_LAST) begin
         out_byte = hdr_byte;
      end else if (phase_ff == PH_INFO) begin
         out_byte = item_ff.info_byte;
      end else if (phase_ff == PH_FCS_LO) begin
         out_byte = ~crc_ff[7:0];
      end else begin
         out_byte = ~crc_ff[15:8];
      end
   end

   // Next phase of the current item, or done
   always_comb begin
      item_done = 1'b0;
      phase_nxt = phase_ff + 5'd1;
      priority if (phase_ff == PH_HDR_LAST) begin
         if (item_ff.has_byte) begin
            phase_nxt = PH_INFO;
         end else if (item_ff.end_of_info) begin
            phase_nxt = PH_FCS_LO;
         end else begin
            item_done = 1'b1;
         end
      end else if (phase_ff == PH_INFO) begin
         phase_nxt = PH_FCS_LO;
         item_done = !item_ff.end_of_info;
      end else if (phase_ff == PH_FCS_HI) begin
         item_done = 1'b1;
      end else begin
         phase_nxt = phase_ff + 5'd1;
      end
   end

   assign step      = item_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_vld_ff && !(step && item_done);
   assign accept    = req_valid && !req_stall;

   // Frame state as it stands once this cycle's byte is out
   always_comb begin
      crc_in      = crc_ff;
      hdr_sent_in = hdr_sent_ff;
      if (step) begin
         if (phase_ff == PH_FCS_HI) begin
            crc_in      = CRC_INIT;
            hdr_sent_in = 1'b0;
         end else if (phase_ff <= PH_INFO) begin
            crc_in      = crc_upd;
            hdr_sent_in = 1'b1;
         end
      end
   end

   always_comb begin
      start_ok    = 1'b1;
      start_phase = PH_HDR_FIRST;
      priority if (!hdr_sent_in) begin
         start_phase = PH_HDR_FIRST;
      end else if (req_data.has_byte) begin
         start_phase = PH_INFO;
      end else if (req_data.end_of_info) begin
         start_phase = PH_FCS_LO;
      end else begin
         // empty item mid-frame: drop
         start_ok = 1'b0;
      end
   end

   always_comb begin
      item_in     = item_ff;
      item_vld_in = item_vld_ff;
      phase_in    = phase_ff;
      if (step) begin
         phase_in = phase_nxt;
         if (item_done) item_vld_in = 1'b0;
      end
      if (accept) begin
         item_in     = req_data;
         item_vld_in = start_ok;
         phase_in    = start_phase;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.frame_byte = out_byte;
         rsp_data_in.frame_end  = (phase_ff == PH_FCS_HI);
      end
   end

   always_comb begin
      dest_in = dest_ff;
      src_in  = src_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_DEST_CALL:   dest_in = csr_wdata;
            CSR_SOURCE_CALL: src_in  = csr_wdata;
            default:         dest_in = dest_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff      <= '0;
         src_ff       <= '0;
         item_vld_ff  <= 1'b0;
         phase_ff     <= PH_HDR_FIRST;
         crc_ff       <= CRC_INIT;
         hdr_sent_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dest_ff      <= dest_in;
         src_ff       <= src_in;
         item_vld_ff  <= item_vld_in;
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         hdr_sent_ff  <= hdr_sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
   import afb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned SETTLE      = 4;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wen = 1'b0;
   csr_index_type     csr_index = CSR_DEST_CALL;
   logic [CALL_W-1:0] csr_wdata = '0;

   // predictor copy of the block
   logic [CALL_W-1:0] model_dest_call;
   logic [CALL_W-1:0] model_src_call;
   logic [15:0]       model_fcs;
   logic              model_hdr_out;

   rsp_type frame_q[$];
   rsp_type want;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned n_items       = 0;
   int unsigned n_bytes       = 0;
   int unsigned n_frames      = 0;
   int unsigned n_errors      = 0;
   int unsigned n_cycles      = 0;

   ax25_ui_frame_builder_fcs u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      int          j;
      c = acc ^ {8'h00, b};
      for (j = 0; j < 8; j++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic expect_byte(input logic [7:0] b, input logic last, input logic in_fcs);
      rsp_type e;
      if (in_fcs)
         model_fcs = fcs_update(model_fcs, b);
      e.frame_byte = b;
      e.frame_end  = last;
      frame_q.push_back(e);
   endtask

   task automatic expect_address(input logic [CALL_W-1:0] call, input logic [7:0] ssid);
      logic [7:0] ch;
      logic       ended;
      int         k;
      ended = 1'b0;
      for (k = 0; k < CHARS; k++) begin
         ch = call[CALL_W-1-8*k -: 8];
         if (ch == 8'h00)
            ended = 1'b1;
         if (ended)
            ch = PAD_CHAR;
         expect_byte({ch[6:0], 1'b0} & SHIFT_MASK, 1'b0, 1'b1);
      end
      expect_byte(ssid, 1'b0, 1'b1);
   endtask

   task automatic predict_frame_bytes(input req_type r);
      logic [15:0] f;
      if (!model_hdr_out) begin
         model_fcs = CRC_INIT;
         expect_address(model_dest_call, SSID_BASE);
         expect_address(model_src_call, SSID_BASE | SSID_LAST);
         expect_byte(CTRL_UI, 1'b0, 1'b1);
         expect_byte(PID_NONE, 1'b0, 1'b1);
         model_hdr_out = 1'b1;
      end
      if (r.has_byte)
         expect_byte(r.info_byte, 1'b0, 1'b1);
      if (r.end_of_info) begin
         f = ~model_fcs;
         expect_byte(f[7:0], 1'b0, 1'b0);
         expect_byte(f[15:8], 1'b1, 1'b0);
         model_fcs     = CRC_INIT;
         model_hdr_out = 1'b0;
      end
   endtask

   // check results, then predict from the item and register write taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         model_dest_call = '0;
         model_src_call  = '0;
         model_fcs       = CRC_INIT;
         model_hdr_out   = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_bytes++;
            if (rsp_data.frame_end)
               n_frames++;
            if (frame_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("unexpected frame byte %02h end %0d",
                           rsp_data.frame_byte, rsp_data.frame_end);
            end else begin
               want = frame_q.pop_front();
               if (rsp_data.frame_byte !== want.frame_byte ||
                   rsp_data.frame_end !== want.frame_end) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display("frame byte mismatch: expected %02h end %0d, got %02h end %0d",
                              want.frame_byte, want.frame_end,
                              rsp_data.frame_byte, rsp_data.frame_end);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_frame_bytes(req_data);
         if (csr_wen) begin
            if (csr_index == CSR_DEST_CALL)
               model_dest_call = csr_wdata;
            else
               model_src_call = csr_wdata;
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input logic has, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_data.info_byte    <= b;
      req_data.has_byte     <= has;
      req_data.end_of_info  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      n_items++;
   endtask

   // hold off until every predicted byte is out and the sequencer has settled
   task automatic wait_frame_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CALL_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_callsigns(input logic [CALL_W-1:0] dest, input logic [CALL_W-1:0] src);
      wait_frame_drain();
      write_csr(CSR_DEST_CALL, dest);
      write_csr(CSR_SOURCE_CALL, src);
   endtask

   function automatic logic [CALL_W-1:0] random_callsign();
      logic [CALL_W-1:0] v;
      int unsigned       len;
      int unsigned       sym;
      int                k;
      v = '0;
      if ($urandom_range(0, 3) == 0) begin
         v[47:32] = 16'($urandom);
         v[31:0]  = $urandom;
      end else begin
         len = $urandom_range(1, CHARS);
         for (k = 0; k < len; k++) begin
            sym = $urandom_range(0, 35);
            v[CALL_W-1-8*k -: 8] = (sym < 26) ? 8'(8'h41 + sym) : 8'(8'h30 + sym - 26);
         end
      end
      return v;
   endfunction

   task automatic test_directed_frames();
      set_callsigns("KQ7XYZ", "WX3ABC");
      // empty final item with no frame open: header then FCS
      send_item(8'h00, 1'b0, 1'b1);
      // single-item frame: the longest burst
      send_item(8'hA5, 1'b1, 1'b1);
      // empty opening item, empty mid-frame item, byte extremes, empty close
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // registers rewritten with a frame open take effect at the next header
      send_item(8'h55, 1'b1, 1'b0);
      set_callsigns('0, '1);
      send_item(8'hAA, 1'b1, 1'b1);
      send_item(8'h3C, 1'b1, 1'b1);
      // zero characters part way through pad the rest of the callsign
      set_callsigns(48'h4142_0043_4445, 48'h5100_0000_0000);
      send_item(8'h7E, 1'b1, 1'b0);
      send_item(8'h81, 1'b1, 1'b1);
   endtask

   task automatic test_random_frames(input int unsigned idle_pct, input int unsigned hold_pct,
                                     input int unsigned budget);
      int unsigned done;
      int unsigned nb;
      int unsigned i;
      logic        paused;
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      done          = 0;
      paused        = 1'b0;
      while (done < budget) begin
         if (!paused && done >= budget / 2) begin
            wait_frame_drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(8'($urandom), 1'($urandom), 1'($urandom));
            done++;
         end else begin
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
            for (i = 0; i < nb; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  send_item(8'($urandom), 1'b0, 1'b0);
                  done++;
               end
               send_item(8'($urandom), 1'b1, 1'b0);
            end
            send_item(8'($urandom), 1'($urandom), 1'b1);
            done += nb + 1;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      set_callsigns(random_callsign(), random_callsign());
      test_random_frames(0, 0, 110);
      set_callsigns('1, '0);
      test_random_frames(85, 0, 110);
      set_callsigns(random_callsign(), random_callsign());
      test_random_frames(0, 85, 110);
      set_callsigns(random_callsign(), '1);
      test_random_frames(28, 28, 110);
      wait_frame_drain();
      repeat (20) @(posedge clock);
      $display("%0d items sent, %0d frame bytes checked, %0d frames closed", n_items, n_bytes,
               n_frames);
      $display("covered directed edge cases, callsign extremes and four pacing mixes");
      if (n_errors == 0 && frame_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
